FILE: sv/mtru_pkg.sv
// Shared types and constants for the microtubule reaction update block.
// Holds the table entry layout, reaction and error codes, and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package mtru_pkg;

	localparam int NUM_MT       = 64;
	localparam int MT_IDX_W     = $clog2(NUM_MT);
	localparam int NUM_PROTEINS = 5;
	localparam int PROT_IDX_W   = 3;
	localparam int DIST_W       = 12;
	localparam int POS_W        = 16;
	localparam int CNT_W        = 8;
	localparam int POOL_W       = 16;
	localparam int FLUX_W       = 22;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;

	localparam logic [DIST_W-1:0] THRESH_RESET = 12'd50;
	localparam logic [11:0]       TABLE_RESET  = 12'd1161;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TABLE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL0  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL4  = 3'd6;

	localparam logic OPC_APPLY   = 1'b0;
	localparam logic OPC_RESTART = 1'b1;

	// Minus-end reaction set
	localparam logic [4:0] RXN_M_ASSOC     = 5'd0;
	localparam logic [4:0] RXN_M_DISSOC    = 5'd1;
	localparam logic [4:0] RXN_M_GROW      = 5'd2;
	localparam logic [4:0] RXN_M_SHRINK    = 5'd3;
	localparam logic [4:0] RXN_M_SWITCH_LO = 5'd4;
	localparam logic [4:0] RXN_M_SWITCH_HI = 5'd9;
	// Plus-end reaction set
	localparam logic [4:0] RXN_P_ASSOC_LO  = 5'd0;
	localparam logic [4:0] RXN_P_ASSOC_HI  = 5'd4;
	localparam logic [4:0] RXN_P_DISSOC_LO = 5'd5;
	localparam logic [4:0] RXN_P_DISSOC_HI = 5'd9;
	localparam logic [4:0] RXN_P_GROW      = 5'd10;
	localparam logic [4:0] RXN_P_SHRINK    = 5'd11;
	localparam logic [4:0] RXN_P_SWITCH_LO = 5'd12;
	localparam logic [4:0] RXN_P_SWITCH_HI = 5'd17;

	typedef enum logic [2:0] {
		OP_ASSOC,
		OP_DISSOC,
		OP_GROW,
		OP_SHRINK,
		OP_SWITCH,
		OP_BAD
	} op_t;

	typedef enum logic [2:0] {
		ERR_OK,
		ERR_CLAMP,
		ERR_POOL,
		ERR_BOUND,
		ERR_BAD
	} err_t;

	typedef struct packed {
		logic [DIST_W-1:0]                  dm;
		logic [DIST_W-1:0]                  dp;
		logic signed [POS_W-1:0]            pos;
		logic [1:0]                         sm;
		logic [1:0]                         sp;
		logic [NUM_PROTEINS-1:0][CNT_W-1:0] bound;
		logic [CNT_W-1:0]                   total;
	} entry_t;

endpackage

FILE: sv/microtubule_reaction_update.sv
// Top level of the microtubule reaction update block.
// Holds the entry memory, valid bits, protein pool, flux and update logic.
// Depends on mtru_pkg.
`timescale 1ns / 1ps

// Usage:
//   Command channel: an item (opcode, mt_index, end_select, reaction_index)
//   is taken at a rising edge with start high and busy low. busy stays low,
//   so one item can be issued every cycle.
//   Result channel: done is high for one cycle with the entry after the step,
//   the flux and error_code, all from the result register. The command edge
//   loads the input register and the registered entry memory read, and the
//   result register is loaded from them. Back-to-back commands on the same
//   microtubule see each other's updates through a bypass on the memory read.
//   Throughput: one item per cycle; an apply item does one read-modify-write
//   of its memory row.
//   Configuration: cfg_valid/cfg_ready write channel, cfg_ready always high;
//   index 0 threshold, 1 switch table, 2..6 initial pools. Write only while
//   no command is in flight.
//   Reset: all entries read as zero, pool and flux zero, registers at their
//   reset values. A restart command clears the table, reloads the pool and
//   clears the flux. The receiver cannot stall results.

module microtubule_reaction_update (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                opcode,
	input  logic [mtru_pkg::MT_IDX_W-1:0]       mt_index,
	input  logic                                end_select,
	input  logic [4:0]                          reaction_index,
	output logic                                done,
	output logic [mtru_pkg::DIST_W-1:0]         dist_minus_out,
	output logic [mtru_pkg::DIST_W-1:0]         dist_plus_out,
	output logic signed [mtru_pkg::POS_W-1:0]   position_out,
	output logic [1:0]                          status_minus_out,
	output logic [1:0]                          status_plus_out,
	output logic [mtru_pkg::CNT_W-1:0]          bound_total_out,
	output logic signed [mtru_pkg::FLUX_W-1:0]  flux_out,
	output logic [2:0]                          error_code,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mtru_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mtru_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic [mtru_pkg::DIST_W-1:0] thresh_q;
	logic [11:0]                 table_q;
	logic [mtru_pkg::POOL_W-1:0] init_pool_q [mtru_pkg::NUM_PROTEINS];

	logic [mtru_pkg::POOL_W-1:0]        pool_q [mtru_pkg::NUM_PROTEINS];
	logic [mtru_pkg::POOL_W-1:0]        pool_d [mtru_pkg::NUM_PROTEINS];
	logic signed [mtru_pkg::FLUX_W-1:0] flux_q;
	logic signed [mtru_pkg::FLUX_W-1:0] flux_d;
	logic [mtru_pkg::NUM_MT-1:0]        valid_q;

	mtru_pkg::entry_t entry_mem [mtru_pkg::NUM_MT];
	mtru_pkg::entry_t rd_s1;

	logic                          accept;
	logic                          valid_s1;
	logic                          opcode_s1;
	logic [mtru_pkg::MT_IDX_W-1:0] idx_s1;
	logic                          end_s1;
	logic [4:0]                    rxn_s1;

	mtru_pkg::entry_t cur;
	mtru_pkg::entry_t nxt;
	mtru_pkg::op_t    op;
	mtru_pkg::err_t   err;
	logic [mtru_pkg::PROT_IDX_W-1:0] prot;
	logic [2:0]                      sw_k;
	logic [1:0]                      sw_state;
	logic                            mem_we;
	logic                            restart;

	logic                               done_q;
	mtru_pkg::entry_t                   res_q;
	logic signed [mtru_pkg::FLUX_W-1:0] res_flux_q;
	mtru_pkg::err_t                     res_err_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start & ~busy;
	assign restart   = valid_s1 && (opcode_s1 == mtru_pkg::OPC_RESTART);
	assign mem_we    = valid_s1 && (opcode_s1 == mtru_pkg::OPC_APPLY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= mtru_pkg::THRESH_RESET;
			table_q  <= mtru_pkg::TABLE_RESET;
			for (int i = 0; i < mtru_pkg::NUM_PROTEINS; i++) begin
				init_pool_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index) inside
				mtru_pkg::CFG_THRESH: begin
					thresh_q <= cfg_data[mtru_pkg::DIST_W-1:0];
				end
				mtru_pkg::CFG_TABLE: begin
					table_q <= cfg_data[11:0];
				end
				[mtru_pkg::CFG_POOL0:mtru_pkg::CFG_POOL4]: begin
					init_pool_q[3'(cfg_index - mtru_pkg::CFG_POOL0)] <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		opcode_s1 <= opcode;
		idx_s1    <= mt_index;
		end_s1    <= end_select;
		rxn_s1    <= reaction_index;
	end

	// Entry memory: one write port, one registered read port with bypass
	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem[idx_s1] <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we && idx_s1 == mt_index) begin
			rd_s1 <= nxt;
		end else begin
			rd_s1 <= entry_mem[mt_index];
		end
	end

	always_comb begin
		op   = mtru_pkg::OP_BAD;
		prot = '0;
		sw_k = '0;
		if (!end_s1) begin
			case (rxn_s1) inside
				mtru_pkg::RXN_M_ASSOC: begin
					op = mtru_pkg::OP_ASSOC;
				end
				mtru_pkg::RXN_M_DISSOC: begin
					op = mtru_pkg::OP_DISSOC;
				end
				mtru_pkg::RXN_M_GROW: begin
					op = mtru_pkg::OP_GROW;
				end
				mtru_pkg::RXN_M_SHRINK: begin
					op = mtru_pkg::OP_SHRINK;
				end
				[mtru_pkg::RXN_M_SWITCH_LO:mtru_pkg::RXN_M_SWITCH_HI]: begin
					op   = mtru_pkg::OP_SWITCH;
					sw_k = 3'(rxn_s1 - mtru_pkg::RXN_M_SWITCH_LO);
				end
				default: begin
					op = mtru_pkg::OP_BAD;
				end
			endcase
		end else begin
			case (rxn_s1) inside
				[mtru_pkg::RXN_P_ASSOC_LO:mtru_pkg::RXN_P_ASSOC_HI]: begin
					op   = mtru_pkg::OP_ASSOC;
					prot = 3'(rxn_s1 - mtru_pkg::RXN_P_ASSOC_LO);
				end
				[mtru_pkg::RXN_P_DISSOC_LO:mtru_pkg::RXN_P_DISSOC_HI]: begin
					op   = mtru_pkg::OP_DISSOC;
					prot = 3'(rxn_s1 - mtru_pkg::RXN_P_DISSOC_LO);
				end
				mtru_pkg::RXN_P_GROW: begin
					op = mtru_pkg::OP_GROW;
				end
				mtru_pkg::RXN_P_SHRINK: begin
					op = mtru_pkg::OP_SHRINK;
				end
				[mtru_pkg::RXN_P_SWITCH_LO:mtru_pkg::RXN_P_SWITCH_HI]: begin
					op   = mtru_pkg::OP_SWITCH;
					sw_k = 3'(rxn_s1 - mtru_pkg::RXN_P_SWITCH_LO);
				end
				default: begin
					op = mtru_pkg::OP_BAD;
				end
			endcase
		end
	end

	assign sw_state = 2'(table_q >> {sw_k, 1'b0});

	always_comb begin
		cur = valid_q[idx_s1] ? rd_s1 : '0;
		nxt = cur;
		err = mtru_pkg::ERR_OK;
		for (int i = 0; i < mtru_pkg::NUM_PROTEINS; i++) begin
			pool_d[i] = pool_q[i];
		end
		case (op)
			mtru_pkg::OP_ASSOC: begin
				if (pool_q[prot] == '0) begin
					err = mtru_pkg::ERR_POOL;
				end else begin
					pool_d[prot] = pool_q[prot] - 1'b1;
					if (cur.bound[prot] != '1) begin
						nxt.bound[prot] = cur.bound[prot] + 1'b1;
					end
					if (cur.total != '1) begin
						nxt.total = cur.total + 1'b1;
					end
				end
			end
			mtru_pkg::OP_DISSOC: begin
				if (cur.bound[prot] == '0 || cur.total == '0) begin
					err = mtru_pkg::ERR_BOUND;
				end else begin
					if (pool_q[prot] != '1) begin
						pool_d[prot] = pool_q[prot] + 1'b1;
					end
					nxt.bound[prot] = cur.bound[prot] - 1'b1;
					nxt.total       = cur.total - 1'b1;
				end
			end
			mtru_pkg::OP_GROW: begin
				if (!end_s1) begin
					if (cur.dm == '0) begin
						if (cur.dp == '0) begin
							err = mtru_pkg::ERR_CLAMP;
						end else begin
							nxt.dp = cur.dp - 1'b1;
						end
						if (cur.pos != 16'sh8000) begin
							nxt.pos = cur.pos - 16'sd1;
						end
					end else begin
						nxt.dm = cur.dm - 1'b1;
					end
				end else begin
					if (cur.dp == '0) begin
						if (cur.dm == '0) begin
							err = mtru_pkg::ERR_CLAMP;
						end else begin
							nxt.dm = cur.dm - 1'b1;
						end
						if (cur.pos != 16'sh7FFF) begin
							nxt.pos = cur.pos + 16'sd1;
						end
					end else begin
						nxt.dp = cur.dp - 1'b1;
					end
				end
			end
			mtru_pkg::OP_SHRINK: begin
				if (!end_s1) begin
					if (cur.dm < thresh_q && cur.dp < thresh_q) begin
						if (cur.pos != 16'sh7FFF) begin
							nxt.pos = cur.pos + 16'sd1;
						end
						if (cur.dp != '1) begin
							nxt.dp = cur.dp + 1'b1;
						end
					end else if (cur.dm != '1) begin
						nxt.dm = cur.dm + 1'b1;
					end
				end else begin
					if (cur.dp >= thresh_q) begin
						if (cur.dm != '1) begin
							nxt.dm = cur.dm + 1'b1;
						end
						if (cur.pos != 16'sh8000) begin
							nxt.pos = cur.pos - 16'sd1;
						end
					end else if (cur.dp != '1) begin
						nxt.dp = cur.dp + 1'b1;
					end
				end
			end
			mtru_pkg::OP_SWITCH: begin
				if (!end_s1) begin
					nxt.sm = sw_state;
				end else begin
					nxt.sp = sw_state;
				end
			end
			default: begin
				err = mtru_pkg::ERR_BAD;
			end
		endcase
		flux_d = flux_q
			+ {{(mtru_pkg::FLUX_W-mtru_pkg::POS_W){nxt.pos[mtru_pkg::POS_W-1]}}, nxt.pos}
			- {{(mtru_pkg::FLUX_W-mtru_pkg::POS_W){cur.pos[mtru_pkg::POS_W-1]}}, cur.pos};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			flux_q  <= '0;
			for (int i = 0; i < mtru_pkg::NUM_PROTEINS; i++) begin
				pool_q[i] <= '0;
			end
		end else if (restart) begin
			valid_q <= '0;
			flux_q  <= '0;
			for (int i = 0; i < mtru_pkg::NUM_PROTEINS; i++) begin
				pool_q[i] <= init_pool_q[i];
			end
		end else if (mem_we) begin
			valid_q[idx_s1] <= 1'b1;
			flux_q          <= flux_d;
			for (int i = 0; i < mtru_pkg::NUM_PROTEINS; i++) begin
				pool_q[i] <= pool_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (restart) begin
			res_q      <= '0;
			res_flux_q <= '0;
			res_err_q  <= mtru_pkg::ERR_OK;
		end else begin
			res_q      <= nxt;
			res_flux_q <= flux_d;
			res_err_q  <= err;
		end
	end

	assign done             = done_q;
	assign dist_minus_out   = res_q.dm;
	assign dist_plus_out    = res_q.dp;
	assign position_out     = res_q.pos;
	assign status_minus_out = res_q.sm;
	assign status_plus_out  = res_q.sp;
	assign bound_total_out  = res_q.total;
	assign flux_out         = res_flux_q;
	assign error_code       = res_err_q;

endmodule
